// File: rtl/core/feal8_pkg.sv
// ============================================================================
// feal8_pkg
// Shared types, constants and FEAL mixing functions for the FEAL-8 engine.
// ============================================================================
`default_nettype none

package feal8_pkg;

    localparam int unsigned BLOCK_W    = 64;
    localparam int unsigned HALF_W     = 32;
    localparam int unsigned SUBKEY_W   = 16;
    localparam int unsigned NUM_ROUNDS = 8;
    // whitening stage + one stage per round + output register
    localparam int unsigned PIPE_DEPTH = NUM_ROUNDS + 2;
    localparam int unsigned ADDR_W     = 4;
    localparam int unsigned DATA_W     = 64;

    typedef enum logic [0:0] {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        REG_CIPHER_KEY = 1'b0
    } reg_idx_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [HALF_W-1:0] l;
        logic [HALF_W-1:0] r;
    } stage_t;

    typedef struct packed {
        logic                                 done;
        logic [NUM_ROUNDS-1:0][SUBKEY_W-1:0]  rkey;
        logic [BLOCK_W-1:0]                   pre_white;
        logic [BLOCK_W-1:0]                   post_white;
    } ks_out_t;

    // add with carry-in, then rotate left by two
    function automatic logic [7:0] sbox_add(input logic [7:0] a, input logic [7:0] b,
                                            input logic d);
        logic [7:0] s;
        s = a + b + {7'd0, d};
        return {s[5:0], s[7:6]};
    endfunction

    function automatic logic [31:0] mix_f(input logic [31:0] al, input logic [15:0] k);
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] y2;
        logic [7:0] y3;
        p  = al[7:0] ^ al[15:8] ^ k[7:0];
        q  = al[23:16] ^ al[31:24] ^ k[15:8];
        y1 = sbox_add(p, q, 1'b1);
        y2 = sbox_add(q, y1, 1'b0);
        y0 = sbox_add(al[7:0], y1, 1'b0);
        y3 = sbox_add(al[31:24], y2, 1'b1);
        return {y3, y2, y1, y0};
    endfunction

    function automatic logic [31:0] mix_fk(input logic [31:0] al, input logic [31:0] be);
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] y2;
        logic [7:0] y3;
        p  = al[7:0] ^ al[15:8];
        q  = al[23:16] ^ al[31:24];
        y1 = sbox_add(p, q ^ be[7:0], 1'b1);
        y2 = sbox_add(q, y1 ^ be[15:8], 1'b0);
        y0 = sbox_add(al[7:0], y1 ^ be[23:16], 1'b0);
        y3 = sbox_add(al[31:24], y2 ^ be[31:24], 1'b1);
        return {y3, y2, y1, y0};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/feal8_keysched.sv
// ============================================================================
// feal8_keysched
// Iterative FEAL key schedule: one fK pass per cycle, eight passes per key.
// ============================================================================
`default_nettype none

module feal8_keysched (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               restart,
    input  wire logic [feal8_pkg::BLOCK_W-1:0]      cipher_key,
    output feal8_pkg::ks_out_t                      ks
);

    localparam int unsigned CNT_W = $clog2(feal8_pkg::NUM_ROUNDS + 1);
    localparam int unsigned IDX_W = $clog2(feal8_pkg::NUM_ROUNDS);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(feal8_pkg::NUM_ROUNDS);

    logic                             load_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [feal8_pkg::HALF_W-1:0]     a_reg;
    logic [feal8_pkg::HALF_W-1:0]     b_reg;
    logic [feal8_pkg::HALF_W-1:0]     d_reg;
    logic [feal8_pkg::HALF_W-1:0]     sk_reg [feal8_pkg::NUM_ROUNDS];
    logic [feal8_pkg::HALF_W-1:0]     y;
    logic                             running;

    assign y       = feal8_pkg::mix_fk(a_reg, b_reg ^ d_reg);
    assign running = !load_reg && (cnt_reg != CNT_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (restart)
        begin
            load_reg <= 1'b1;
        end
        else if (load_reg)
        begin
            load_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (running)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            a_reg <= cipher_key[feal8_pkg::HALF_W-1:0];
            b_reg <= cipher_key[feal8_pkg::BLOCK_W-1:feal8_pkg::HALF_W];
            d_reg <= '0;
        end
        else if (running)
        begin
            d_reg <= a_reg;
            a_reg <= b_reg;
            b_reg <= y;
            sk_reg[cnt_reg[IDX_W-1:0]] <= y;
        end
    end

    always_comb
    begin
        ks.done = !load_reg && (cnt_reg == CNT_END) && !restart;
        for (int i = 0; i < feal8_pkg::NUM_ROUNDS / 2; i++)
        begin
            ks.rkey[2*i]   = sk_reg[i][15:0];
            ks.rkey[2*i+1] = sk_reg[i][31:16];
        end
        ks.pre_white  = {sk_reg[5], sk_reg[4]};
        ks.post_white = {sk_reg[7], sk_reg[6]};
    end

endmodule

`default_nettype wire

// File: rtl/core/feal8_round.sv
// ============================================================================
// feal8_round
// One pipelined Feistel round: new L = R, new R = L ^ f(R, key).
// ============================================================================
`default_nettype none

module feal8_round (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic                              in_valid,
    input  wire feal8_pkg::stage_t                 in_stage,
    input  wire logic [feal8_pkg::SUBKEY_W-1:0]    round_key,
    output logic                                   out_valid,
    output feal8_pkg::stage_t                      out_stage
);

    logic               valid_reg;
    feal8_pkg::stage_t  stage_reg;
    feal8_pkg::stage_t  stage_next;

    always_comb
    begin
        stage_next.cmd = in_stage.cmd;
        stage_next.l   = in_stage.r;
        stage_next.r   = in_stage.l ^ feal8_pkg::mix_f(in_stage.r, round_key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

// File: rtl/core/feal8_block_cipher.sv
// ============================================================================
// feal8_block_cipher
// FEAL-8 encrypt/decrypt engine with APB key register and streaming pipeline.
// ============================================================================
// The block takes one 64-bit block per cycle while in_ready is high and passes it
// through the whitening stage, eight round stages and output register, so it sustains
// one block per clock while out_ready stays high; each round stage holds one f function
// with its four 8-bit adders, at most three of them chained. Each stage stalls only
// when it is full and the stage after it is stalled, so bubbles are squeezed out. After
// reset and after every write of the key register, the iterative key schedule runs one
// fK pass per cycle; in_ready stays low after reset, and from the access cycle of a key
// write, until the sixteen subkeys are ready.
// Write the key only while no block is in flight.
`default_nettype none

module feal8_block_cipher (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [feal8_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [feal8_pkg::DATA_W-1:0]       pwdata,
    output logic      [feal8_pkg::DATA_W-1:0]       prdata,
    output logic                                    pready,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               cmd,
    input  wire logic [feal8_pkg::BLOCK_W-1:0]      data_block,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [feal8_pkg::BLOCK_W-1:0]      result_block
);

    localparam int unsigned NR    = feal8_pkg::NUM_ROUNDS;
    localparam int unsigned DEPTH = feal8_pkg::PIPE_DEPTH;
    localparam int unsigned HW    = feal8_pkg::HALF_W;

    // ---------------- configuration ----------------
    logic                              cfg_wr;
    logic                              key_wr;
    logic [feal8_pkg::BLOCK_W-1:0]     cipher_key_reg;
    feal8_pkg::reg_idx_t               wr_idx;
    feal8_pkg::ks_out_t                ks;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wr_idx = feal8_pkg::reg_idx_t'(paddr[feal8_pkg::ADDR_W-1:3]);

    always_comb
    begin
        key_wr = 1'b0;
        prdata = '0;
        case (wr_idx)
            feal8_pkg::REG_CIPHER_KEY:
            begin
                key_wr = cfg_wr;
                prdata = cipher_key_reg;
            end
            default:
            begin
                key_wr = 1'b0;
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= '0;
        end
        else if (key_wr)
        begin
            cipher_key_reg <= pwdata;
        end
    end

    feal8_keysched u_keysched (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (key_wr),
        .cipher_key (cipher_key_reg),
        .ks         (ks)
    );

    // ---------------- pipeline flow control ----------------
    logic [DEPTH-1:0]   valid_q;
    logic [DEPTH-1:0]   take;
    logic               accept;

    always_comb
    begin
        take[DEPTH-1] = !valid_q[DEPTH-1] || out_ready;
        for (int i = DEPTH - 2; i >= 0; i--)
        begin
            take[i] = !valid_q[i] || take[i+1];
        end
    end

    assign in_ready = take[0] && ks.done && !cfg_wr;
    assign accept   = in_valid && in_ready;

    // ---------------- whitening stage ----------------
    logic                          s0_valid_reg;
    feal8_pkg::stage_t             s0_stage_reg;
    feal8_pkg::stage_t             s0_stage_next;
    feal8_pkg::cmd_t               in_cmd;
    logic [feal8_pkg::BLOCK_W-1:0] x;

    assign in_cmd = feal8_pkg::cmd_t'(cmd);

    always_comb
    begin
        x = data_block ^ ((in_cmd == feal8_pkg::CMD_DECRYPT) ? ks.post_white : ks.pre_white);
        s0_stage_next.cmd = in_cmd;
        s0_stage_next.l   = x[HW-1:0];
        s0_stage_next.r   = x[2*HW-1:HW] ^ x[HW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (take[0])
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[0] && accept)
        begin
            s0_stage_reg <= s0_stage_next;
        end
    end

    // ---------------- round stages ----------------
    feal8_pkg::stage_t  stage_q [NR+1];

    assign valid_q[0] = s0_valid_reg;
    assign stage_q[0] = s0_stage_reg;

    for (genvar g = 1; g <= NR; g++)
    begin : g_round
        logic [feal8_pkg::SUBKEY_W-1:0] key_sel;

        // decryption walks the round keys backward
        assign key_sel = (stage_q[g-1].cmd == feal8_pkg::CMD_DECRYPT) ?
                         ks.rkey[NR-g] : ks.rkey[g-1];

        feal8_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (take[g]),
            .in_valid  (valid_q[g-1]),
            .in_stage  (stage_q[g-1]),
            .round_key (key_sel),
            .out_valid (valid_q[g]),
            .out_stage (stage_q[g])
        );
    end

    // ---------------- output stage ----------------
    logic                          out_valid_reg;
    logic [feal8_pkg::BLOCK_W-1:0] result_reg;
    logic [feal8_pkg::BLOCK_W-1:0] result_next;

    always_comb
    begin
        result_next = {stage_q[NR].l ^ stage_q[NR].r, stage_q[NR].r} ^
                      ((stage_q[NR].cmd == feal8_pkg::CMD_DECRYPT) ?
                       ks.pre_white : ks.post_white);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take[DEPTH-1])
        begin
            out_valid_reg <= valid_q[NR];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[DEPTH-1] && valid_q[NR])
        begin
            result_reg <= result_next;
        end
    end

    assign valid_q[DEPTH-1] = out_valid_reg;
    assign out_valid        = out_valid_reg;
    assign result_block     = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/feal8_checker.sv
// ============================================================================
// feal8_checker
// Port-level checks for the FEAL-8 engine, bound to the top level.
// ============================================================================
`default_nettype none

module feal8_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [feal8_pkg::ADDR_W-1:0]       paddr,
    input  wire logic                               pready,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [feal8_pkg::BLOCK_W-1:0]      result_block
);

    localparam int unsigned OCC_W = $clog2(feal8_pkg::PIPE_DEPTH + 2);

    logic [OCC_W-1:0] occ_reg;
    logic             in_xfer;
    logic             out_xfer;
    logic             key_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign key_xfer = psel && penable && pwrite && pready &&
                      (paddr[feal8_pkg::ADDR_W-1:3] == '0);

    // track blocks in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            occ_reg <= occ_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            occ_reg <= occ_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_block))
        else $error("result changed or dropped while stalled");

    a_key_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        key_xfer |=> !in_ready)
        else $error("input taken right after a key write");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("result shown with no block in flight");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(feal8_pkg::PIPE_DEPTH))
        else $error("more blocks in flight than pipeline stages");

endmodule

bind feal8_block_cipher feal8_checker u_feal8_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_block (result_block)
);

`default_nettype wire
